@@ hw/rtl/rgba_premultiply_swizzle_defines.svh @@
// Assertion macros shared by the pixel converter RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef RGBA_PREMULTIPLY_SWIZZLE_DEFINES_SVH
`define RGBA_PREMULTIPLY_SWIZZLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RPS_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RPS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/rps_pkg.sv @@
// Shared types and constants for the RGBA premultiply / swizzle converter.
// Depends on nothing; imported by rgba_premultiply_swizzle.
package rps_pkg;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_SWAP      = 2'd0;
  localparam mode_t MODE_PREMUL    = 2'd1;
  localparam mode_t MODE_UNPREMUL  = 2'd2;

  localparam int    PADDR_W        = 3;
  localparam logic  REG_MODE       = 1'b0;

  localparam logic [15:0] PREMUL_BIAS = 16'h007f;

  localparam int    NUM_CH         = 3;
  localparam int    DIV_STEPS      = 4;

  // Per-channel state of the restoring divider: partial remainder and the
  // dividend/quotient shift register.
  typedef struct packed {
    logic [7:0]  rem;
    logic [15:0] shf;
  } div_ch_t;

  typedef struct packed {
    mode_t                     mode;
    logic [7:0]                alpha;
    logic [NUM_CH-1:0][7:0]    c;
    logic [NUM_CH-1:0][15:0]   t;
    logic [NUM_CH-1:0][15:0]   n;
  } mul_st_t;

  typedef struct packed {
    mode_t                     mode;
    logic [7:0]                alpha;
    logic [NUM_CH-1:0][7:0]    alt;
    logic [NUM_CH-1:0][7:0]    rem;
    logic [NUM_CH-1:0][15:0]   shf;
  } div_st_t;

endpackage

@@ hw/rtl/rgba_premultiply_swizzle.sv @@
// Top level of the RGBA premultiply / swizzle converter: pipeline, APB mode register.
// Depends on rps_pkg and rgba_premultiply_swizzle_defines.svh.
//
// Converts one 32-bit RGBA8888 pixel per transfer. Bytes 0 and 2 are always
// exchanged and alpha passes straight through; the mode register (APB offset
// 0x0, bits [1:0]) selects swap only (0), swap with premultiply by alpha (1),
// or swap with unpremultiply, colour*255/alpha (2); value 3 acts as swap only.
// Unpremultiply gives 0 for zero alpha and keeps only the low 8 bits of the
// quotient when a colour exceeds alpha. The block takes one pixel every clock
// while no stage is stalled. Stage 1 forms c*a+127 and c*255, stages 2 to 5
// run the 16 restoring division steps four at a time (stage 5 also picks the
// result into the output register). Each stage holds its own valid bit and
// stalls only when it is full and the next stage cannot take its contents, so
// bubbles collapse and input transfers go on while a result waits on out_ready,
// until all stages are full. Write the mode only while the pipeline is empty.
`include "rgba_premultiply_swizzle_defines.svh"

module rgba_premultiply_swizzle
  import rps_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // pixel input
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_byte0,
  input  logic [7:0]         in_byte1,
  input  logic [7:0]         in_byte2,
  input  logic [7:0]         in_alpha,
  // pixel output
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_byte0,
  output logic [7:0]         out_byte1,
  output logic [7:0]         out_byte2,
  output logic [7:0]         out_alpha
);

  // Four restoring division steps: shift one dividend bit into the remainder,
  // subtract the divisor when it fits and shift the quotient bit in.
  function automatic div_ch_t div_step4(input div_ch_t st_in, input logic [7:0] dsr);
    logic [8:0] r9;
    div_ch_t    st;
    st = st_in;
    for (int k = 0; k < DIV_STEPS; k++) begin
      r9     = {st.rem, st.shf[15]};
      st.shf = {st.shf[14:0], 1'b0};
      if (r9 >= {1'b0, dsr}) begin
        r9        = r9 - {1'b0, dsr};
        st.shf[0] = 1'b1;
      end
      st.rem = r9[7:0];
    end
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  mode_t mode;
  logic  reg_wr;

  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_SWAP;
    end else if (reg_wr && (paddr[2] == REG_MODE)) begin
      mode <= pwdata[1:0];
    end
  end

  // Read back the mode at offset 0; nothing else is mapped.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MODE) begin
      prdata = {30'd0, mode};
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline flow control: a stage advances when it is empty or the next
  // stage will take its contents this cycle.
  // ---------------------------------------------------------------------
  logic [5:1] vld;
  logic [5:1] rdy;

  always_comb begin
    rdy[5] = !vld[5] || out_ready;
    for (int k = 4; k >= 1; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[1]) begin
        vld[1] <= in_valid;
      end
      for (int k = 2; k <= 5; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: multiply. Channel index follows the output byte, so the swap
  // of red and blue happens here.
  // ---------------------------------------------------------------------
  mul_st_t                mul_st;
  mul_st_t                mul_next;
  logic [NUM_CH-1:0][7:0] c_in;

  assign c_in[0] = in_byte2;
  assign c_in[1] = in_byte1;
  assign c_in[2] = in_byte0;

  always_comb begin
    mul_next.mode  = mode;
    mul_next.alpha = in_alpha;
    for (int i = 0; i < NUM_CH; i++) begin
      mul_next.c[i] = c_in[i];
      mul_next.t[i] = ({8'd0, c_in[i]} * {8'd0, in_alpha}) + PREMUL_BIAS;
      mul_next.n[i] = {c_in[i], 8'd0} - {8'd0, c_in[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy[1]) begin
      mul_st <= mul_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2 to 4: finish premultiply, then division steps 1 to 12.
  // ---------------------------------------------------------------------
  div_st_t div_st   [2:4];
  div_st_t div_next [2:4];

  always_comb begin
    logic [15:0] sum;
    div_ch_t     ch;
    div_next[2].mode  = mul_st.mode;
    div_next[2].alpha = mul_st.alpha;
    for (int i = 0; i < NUM_CH; i++) begin
      sum = {8'd0, mul_st.t[i][15:8]} + mul_st.t[i];
      div_next[2].alt[i] = (mul_st.mode == MODE_PREMUL) ? sum[15:8] : mul_st.c[i];
      ch.rem = 8'd0;
      ch.shf = mul_st.n[i];
      ch = div_step4(ch, mul_st.alpha);
      div_next[2].rem[i] = ch.rem;
      div_next[2].shf[i] = ch.shf;
    end
    for (int k = 3; k <= 4; k++) begin
      div_next[k] = div_st[k-1];
      for (int i = 0; i < NUM_CH; i++) begin
        ch.rem = div_st[k-1].rem[i];
        ch.shf = div_st[k-1].shf[i];
        ch = div_step4(ch, div_st[k-1].alpha);
        div_next[k].rem[i] = ch.rem;
        div_next[k].shf[i] = ch.shf;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld[1] && rdy[2]) begin
      div_st[2] <= div_next[2];
    end
    for (int k = 3; k <= 4; k++) begin
      if (vld[k-1] && rdy[k]) begin
        div_st[k] <= div_next[k];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: last four division steps and result select into the output
  // register. Zero alpha forces the colours to 0 in unpremultiply mode.
  // ---------------------------------------------------------------------
  logic [NUM_CH-1:0][7:0] res;

  always_comb begin
    div_ch_t ch;
    for (int i = 0; i < NUM_CH; i++) begin
      ch.rem = div_st[4].rem[i];
      ch.shf = div_st[4].shf[i];
      ch = div_step4(ch, div_st[4].alpha);
      if (div_st[4].mode == MODE_UNPREMUL) begin
        res[i] = (div_st[4].alpha == 8'd0) ? 8'd0 : ch.shf[7:0];
      end else begin
        res[i] = div_st[4].alt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (vld[4] && rdy[5]) begin
      out_byte0 <= res[0];
      out_byte1 <= res[1];
      out_byte2 <= res[2];
      out_alpha <= div_st[4].alpha;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RPS_ASSERT_NOW(a_stall_full, clk, rst, !in_ready,
    (&vld) && !out_ready, "input stalled while a pipeline stage is empty")

  `RPS_ASSERT_NOW(a_rem_bound, clk, rst, vld[2] && (div_st[2].alpha != 8'd0),
    (div_st[2].rem[0] < div_st[2].alpha) && (div_st[2].rem[1] < div_st[2].alpha) &&
    (div_st[2].rem[2] < div_st[2].alpha), "divider remainder not below alpha")

  `RPS_ASSERT_NEXT(a_zero_alpha, clk, rst,
    vld[4] && rdy[5] && (div_st[4].mode == MODE_UNPREMUL) && (div_st[4].alpha == 8'd0),
    (out_byte0 == 8'd0) && (out_byte1 == 8'd0) && (out_byte2 == 8'd0),
    "unpremultiply with zero alpha gave non-zero colour")

  `RPS_ASSERT_NEXT(a_swap_pass, clk, rst,
    vld[4] && rdy[5] && (div_st[4].mode == MODE_SWAP),
    (out_byte0 == $past(div_st[4].alt[0])) && (out_alpha == $past(div_st[4].alpha)),
    "swap-only result not passed through")

endmodule

@@ test/testbench.sv @@
// Self-checking bench for rgba_premultiply_swizzle: APB mode setup, pixel stream in and out.
// Depends on rps_pkg and the converter RTL; the expected pixels come from a converter model
// kept here.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rps_pkg::*;

  // Mode value 3 has no name in the package; it must act as swap only.
  localparam mode_t MODE_UNUSED = 2'd3;

  // Byte addresses on the APB port: register i sits at 4*i.
  localparam logic [PADDR_W-1:0] MODE_ADDR   = PADDR_W'(0);
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(4);

  // Cycles to let pass before a mode change, comfortably more than the five pipeline stages.
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] alpha;
  } pixel_t;

  // Converter model plus the queue of pixels still owed by the block.
  class pixel_converter_model;
    mode_t  mode;
    pixel_t owed_pixels[$];
    int     errors;

    function new();
      mode   = MODE_SWAP;
      errors = 0;
    endfunction

    // Register write as seen by the block: only index 0 exists, low two bits kept.
    function void write_reg(int index, logic [31:0] value);
      if (index == int'(REG_MODE))
        mode = value[1:0];
    endfunction

    function logic [7:0] scale_colour(logic [7:0] c, logic [7:0] a);
      logic [31:0] t;
      case (mode)
        MODE_PREMUL: begin
          t = 32'(c) * 32'(a) + 32'(PREMUL_BIAS);
          return 8'(((t >> 8) + t) >> 8);
        end
        MODE_UNPREMUL: begin
          // Zero alpha gives black; an over-range quotient keeps its low byte.
          if (a == 8'd0)
            return 8'd0;
          return 8'((32'(c) * 32'd255) / 32'(a));
        end
        default: return c;
      endcase
    endfunction

    function void note_pixel(pixel_t px);
      pixel_t conv;
      conv.b0    = scale_colour(px.b2, px.alpha);
      conv.b1    = scale_colour(px.b1, px.alpha);
      conv.b2    = scale_colour(px.b0, px.alpha);
      conv.alpha = px.alpha;
      owed_pixels.push_back(conv);
    endfunction

    function void compare_byte(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %02h, got %02h", $time, field, want, got);
      end
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (owed_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel %08h, none outstanding", $time, got);
        return;
      end
      want = owed_pixels.pop_front();
      compare_byte("out_byte0", want.b0, got.b0);
      compare_byte("out_byte1", want.b1, got.b1);
      compare_byte("out_byte2", want.b2, got.b2);
      compare_byte("out_alpha", want.alpha, got.alpha);
    endfunction

    function int pending();
      return owed_pixels.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [7:0]         in_byte0;
  logic [7:0]         in_byte1;
  logic [7:0]         in_byte2;
  logic [7:0]         in_alpha;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_byte0;
  logic [7:0]         out_byte1;
  logic [7:0]         out_byte2;
  logic [7:0]         out_alpha;

  pixel_converter_model conv_model;

  // Idle controls for the stimulus and the output sink.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_off_cycles;

  rgba_premultiply_swizzle u_top (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte0  (in_byte0),
    .in_byte1  (in_byte1),
    .in_byte2  (in_byte2),
    .in_alpha  (in_alpha),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte0 (out_byte0),
    .out_byte1 (out_byte1),
    .out_byte2 (out_byte2),
    .out_alpha (out_alpha)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the pipeline locks up.
  initial begin
    #2_000_000;
    $display("rgba_premultiply_swizzle test failed");
    $finish;
  end

  // Output sink: decide out_ready each falling edge. A requested hold-off is counted down
  // here, cycle by cycle, and overrides the random stalls while it lasts.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ready = 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Check every result transfer against the oldest outstanding pixel.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      conv_model.check_pixel(pixel_t'{out_byte0, out_byte1, out_byte2, out_alpha});
  end

  // Offer one pixel, with random idle cycles in front of it, and hold it until transferred.
  // Valid is left high afterwards so back-to-back pixels never see a dropped valid.
  task automatic send_pixel(input pixel_t px);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      // Junk on the bus while idle must not leak into the pipeline.
      {in_byte0, in_byte1, in_byte2, in_alpha} = $urandom;
      @(negedge clk);
    end
    in_valid = 1'b1;
    {in_byte0, in_byte1, in_byte2, in_alpha} = px;
    do @(posedge clk); while (!in_ready);
    conv_model.note_pixel(px);
  endtask

  task automatic wait_drained();
    while (conv_model.pending() != 0)
      @(posedge clk);
  endtask

  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = addr;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Change the mode only with the pipeline empty: drop valid, drain, let the stages settle,
  // write, then read the register back.
  task automatic configure(input logic [PADDR_W-1:0] addr, input logic [31:0] value);
    logic [31:0] readback;
    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(addr, value);
    conv_model.write_reg(int'(addr) / 4, value);
    apb_read(MODE_ADDR, readback);
    if (readback !== {30'd0, conv_model.mode}) begin
      conv_model.errors++;
      $display("%0t: mode readback mismatch, expected %08h, got %08h",
               $time, {30'd0, conv_model.mode}, readback);
    end
  endtask

  // Random pixel, biased toward the corners of the arithmetic: zero and full alpha,
  // colour above alpha (unpremultiply wraps), properly premultiplied colour, and 00/ff bytes.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     kind;
    px   = $urandom;
    kind = $urandom_range(9);
    case (kind)
      0: px.alpha = 8'h00;
      1: px.alpha = 8'hff;
      2: begin
        px.alpha = 8'($urandom_range(254));
        px.b0    = 8'($urandom_range(255, int'(px.alpha) + 1));
        px.b1    = 8'($urandom_range(255, int'(px.alpha) + 1));
        px.b2    = 8'($urandom_range(255, int'(px.alpha) + 1));
      end
      3: begin
        px.b0 = 8'($urandom_range(int'(px.alpha)));
        px.b1 = 8'($urandom_range(int'(px.alpha)));
        px.b2 = 8'($urandom_range(int'(px.alpha)));
      end
      4: begin
        px.b0    = $urandom_range(1) ? 8'hff : 8'h00;
        px.b1    = $urandom_range(1) ? 8'hff : 8'h00;
        px.b2    = $urandom_range(1) ? 8'hff : 8'h00;
        px.alpha = $urandom_range(1) ? 8'hff : 8'h00;
      end
      default: ;
    endcase
    return px;
  endfunction

  initial begin
    mode_t phase_mode[8];
    int    phase_items;

    conv_model      = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 0;
    phase_items     = 48;
    phase_mode      = '{MODE_SWAP, MODE_PREMUL, MODE_UNPREMUL, MODE_UNUSED,
                        MODE_UNPREMUL, MODE_PREMUL, MODE_UNPREMUL, MODE_SWAP};

    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_valid = 1'b0;
    in_byte0 = '0;
    in_byte1 = '0;
    in_byte2 = '0;
    in_alpha = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: swap only straight after reset.
    send_pixel(pixel_t'{8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel(pixel_t'{8'hff, 8'hff, 8'hff, 8'hff});
    send_pixel(pixel_t'{8'h12, 8'h34, 8'h56, 8'h78});

    // Premultiply: full alpha is identity, zero alpha clears, rounding at mid alpha.
    configure(MODE_ADDR, 32'(MODE_PREMUL));
    send_pixel(pixel_t'{8'hff, 8'hff, 8'hff, 8'hff});
    send_pixel(pixel_t'{8'hff, 8'h80, 8'h01, 8'h00});
    send_pixel(pixel_t'{8'hff, 8'hff, 8'hff, 8'h80});
    send_pixel(pixel_t'{8'h00, 8'h7f, 8'hff, 8'h01});

    // Unpremultiply: zero alpha, full alpha, colour equal to and above alpha.
    configure(MODE_ADDR, 32'(MODE_UNPREMUL));
    send_pixel(pixel_t'{8'hff, 8'h80, 8'h01, 8'h00});
    send_pixel(pixel_t'{8'hff, 8'hff, 8'hff, 8'hff});
    send_pixel(pixel_t'{8'h40, 8'h80, 8'hc0, 8'hc0});
    send_pixel(pixel_t'{8'hff, 8'hc8, 8'h02, 8'h01});
    send_pixel(pixel_t'{8'h80, 8'h40, 8'h20, 8'h7f});
    send_pixel(pixel_t'{8'h00, 8'h00, 8'h00, 8'h01});

    // The spare mode code with every data bit set: behaves as swap only.
    configure(MODE_ADDR, 32'hffff_ffff);
    send_pixel(pixel_t'{8'h01, 8'h02, 8'h03, 8'h04});
    send_pixel(pixel_t'{8'hff, 8'h00, 8'hff, 8'h00});

    // A write to a register that does not exist must leave the mode alone.
    configure(UNUSED_ADDR, 32'(MODE_PREMUL));
    send_pixel(pixel_t'{8'haa, 8'h55, 8'haa, 8'h55});

    // Upper data bits are ignored: this lands as unpremultiply.
    configure(MODE_ADDR, 32'hffff_fffe);
    send_pixel(pixel_t'{8'hff, 8'h40, 8'h10, 8'h20});

    // Random phases: rotate the mode and the idle pattern (none, sender idle, sink
    // stalling, both), and halfway through each phase hold back until the pipeline is empty.
    for (int phase = 0; phase < 8; phase++) begin
      configure(MODE_ADDR, 32'(phase_mode[phase]));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int i = 0; i < phase_items; i++) begin
        if (i == phase_items / 2) begin
          @(negedge clk);
          in_valid = 1'b0;
          wait_drained();
        end
        send_pixel(random_pixel());
      end
    end

    // Back-pressure: hold the sink off for a long stretch while pixels keep coming, so the
    // pipeline fills and in_ready drops.
    configure(MODE_ADDR, 32'(MODE_PREMUL));
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_off_cycles = 250;
    for (int i = 0; i < 40; i++)
      send_pixel(random_pixel());

    @(negedge clk);
    in_valid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (conv_model.errors == 0 && conv_model.pending() == 0)
      $display("rgba_premultiply_swizzle test passed");
    else
      $display("rgba_premultiply_swizzle test failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/rps_pkg.sv
hw/rtl/rgba_premultiply_swizzle.sv
test/testbench.sv
